FILE: rtl/core/lant_pkg.sv
// Shared types and constants for the ant grid stepper.
// Request/result payload structs, operation codes, register indexes and
// the command/status bundles between controller and datapath. No dependencies.
package lant_pkg;

  localparam int COORD_W = 8;
  localparam int DIM_W   = 9;
  localparam int OP_W    = 2;
  localparam int HEAD_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam logic [DIM_W-1:0] CFG_DIM_RESET = DIM_W'(256);

  typedef enum logic [OP_W-1:0] {
    OP_STEP    = 2'd0,
    OP_TOGGLE  = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef enum logic [HEAD_W-1:0] {
    HEAD_NORTH = 2'd0,
    HEAD_EAST  = 2'd1,
    HEAD_SOUTH = 2'd2,
    HEAD_WEST  = 2'd3
  } head_e;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
  } lant_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] ant_x;
    logic [COORD_W-1:0] ant_y;
    logic [HEAD_W-1:0]  heading;
    logic               cell_black;
  } lant_res_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic accept;   // latch request coordinates
    logic clear;    // write zero at sweep address, advance sweep
    logic home;     // put ant at grid center heading north
    logic move;     // flip cell under ant, move one cell
    logic rd_ant;   // read cell under ant
    logic turn;     // turn on read color
    logic rd_cell;  // read toggle target
    logic tog;      // write inverted toggle target
    logic report;   // load result register
  } lant_cmd_t;

  typedef struct packed {
    logic clear_last;
  } lant_sts_t;

endpackage

FILE: rtl/core/lant_datapath.sv
// Datapath of the ant grid stepper: grid memory, ant position/heading,
// size registers, clear sweep counter and result register. Uses lant_pkg.
module lant_datapath import lant_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lant_cmd_t            cmd_i,
  output lant_sts_t            sts_o,
  input  lant_req_t            req_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  output logic                 valid_o,
  output lant_res_t            res_o
);

  localparam int LIM_W = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int LIM_H = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
  localparam int XW = $clog2(LIM_W);
  localparam int YW = $clog2(LIM_H);
  localparam int AW = XW + YW;
  localparam int MEM_DEPTH = 2 ** AW;
  localparam logic [DIM_W-1:0] LIM_W_D = DIM_W'(LIM_W);
  localparam logic [DIM_W-1:0] LIM_H_D = DIM_W'(LIM_H);

  logic [DIM_W-1:0]   width_q, height_q;
  logic [DIM_W-1:0]   eff_w, eff_h;
  logic [COORD_W-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [HEAD_W-1:0]  dir_q, dir_d;
  logic               cell_q, cell_d;
  logic [COORD_W-1:0] tog_x_q, tog_y_q;
  logic               tog_ok;
  logic [AW-1:0]      clr_q;
  logic [AW-1:0]      ant_addr, tog_addr, mem_addr;
  logic               mem_we, mem_re, mem_wdata, rdata_q;
  logic               mem [MEM_DEPTH];
  logic               valid_q;
  lant_res_t          res_q;

  // Size registers, to be written only while idle; the block itself does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_DIM_RESET;
      height_q <= CFG_DIM_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_WIDTH) width_q <= cfg_data_i;
      if (cfg_index_i == CFG_HEIGHT) height_q <= cfg_data_i;
    end
  end

  // Clamp sizes to 1..built limit.
  always_comb begin
    eff_w = (width_q == '0) ? DIM_W'(1) : ((width_q > LIM_W_D) ? LIM_W_D : width_q);
    eff_h = (height_q == '0) ? DIM_W'(1) : ((height_q > LIM_H_D) ? LIM_H_D : height_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      tog_x_q <= req_i.cell_x;
      tog_y_q <= req_i.cell_y;
    end
  end

  assign tog_ok   = ({1'b0, tog_x_q} < eff_w) && ({1'b0, tog_y_q} < eff_h);
  assign ant_addr = {pos_y_q[YW-1:0], pos_x_q[XW-1:0]};
  assign tog_addr = {tog_y_q[YW-1:0], tog_x_q[XW-1:0]};

  // Next ant state.
  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    dir_d   = dir_q;
    cell_d  = cell_q;
    if (cmd_i.home) begin
      pos_x_d = COORD_W'(eff_w >> 1);
      pos_y_d = COORD_W'(eff_h >> 1);
      dir_d   = HEAD_NORTH;
      cell_d  = 1'b0;
    end
    if (cmd_i.move) begin
      case (head_e'(dir_q))
        HEAD_NORTH: pos_y_d = (pos_y_q == '0) ? COORD_W'(eff_h - DIM_W'(1))
                                              : pos_y_q - COORD_W'(1);
        HEAD_EAST:  pos_x_d = ({1'b0, pos_x_q} >= eff_w - DIM_W'(1)) ? '0
                                              : pos_x_q + COORD_W'(1);
        HEAD_SOUTH: pos_y_d = ({1'b0, pos_y_q} >= eff_h - DIM_W'(1)) ? '0
                                              : pos_y_q + COORD_W'(1);
        HEAD_WEST:  pos_x_d = (pos_x_q == '0) ? COORD_W'(eff_w - DIM_W'(1))
                                              : pos_x_q - COORD_W'(1);
        default:    pos_x_d = pos_x_q;
      endcase
    end
    if (cmd_i.turn) begin
      // black: counter-clockwise, white: clockwise
      dir_d  = rdata_q ? dir_q - HEAD_W'(1) : dir_q + HEAD_W'(1);
      cell_d = rdata_q;
    end
    if (cmd_i.tog && tog_ok && (tog_x_q == pos_x_q) && (tog_y_q == pos_y_q)) begin
      cell_d = ~cell_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= COORD_W'(LIM_W / 2);
      pos_y_q <= COORD_W'(LIM_H / 2);
      dir_q   <= HEAD_NORTH;
      cell_q  <= 1'b0;
      clr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      dir_q   <= dir_d;
      cell_q  <= cell_d;
      valid_q <= cmd_i.report;
      if (cmd_i.clear) clr_q <= clr_q + AW'(1);
    end
  end

  assign sts_o.clear_last = &clr_q;

  // Grid memory, one port.
  always_comb begin
    if (cmd_i.clear) begin
      mem_addr = clr_q;
    end else if (cmd_i.rd_cell || cmd_i.tog) begin
      mem_addr = tog_addr;
    end else begin
      mem_addr = ant_addr;
    end
  end

  assign mem_we    = cmd_i.clear || cmd_i.move || (cmd_i.tog && tog_ok);
  assign mem_re    = cmd_i.rd_ant || cmd_i.rd_cell;
  assign mem_wdata = cmd_i.clear ? 1'b0 : (cmd_i.move ? ~cell_q : ~rdata_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.report) begin
      res_q.ant_x      <= pos_x_d;
      res_q.ant_y      <= pos_y_d;
      res_q.heading    <= dir_d;
      res_q.cell_black <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  a_pos_x_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_x_q} < LIM_W_D)
    else $error("ant column beyond grid store");

  a_pos_y_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_y_q} < LIM_H_D)
    else $error("ant row beyond grid store");

  a_clear_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.clear && sts_o.clear_last) |=> (clr_q == '0))
    else $error("clear sweep did not wrap to zero");

endmodule

FILE: rtl/core/lant_ctrl.sv
// Controller of the ant grid stepper: sequences clear sweeps, steps and
// toggles as commands to the datapath. Uses lant_pkg.
module lant_ctrl import lant_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [OP_W-1:0] op_i,
  output logic            busy_o,
  output lant_cmd_t       cmd_o,
  input  lant_sts_t       sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_MOVE,
    S_RDANT,
    S_TURN,
    S_RDCELL,
    S_TOG
  } state_e;

  state_e state_q, state_d;
  logic   report_q, report_d;

  always_comb begin
    state_d  = state_q;
    report_d = report_q;
    cmd_o    = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          case (op_e'(op_i))
            OP_STEP:    state_d = S_MOVE;
            OP_TOGGLE:  state_d = S_RDCELL;
            OP_RESTART: begin
              state_d  = S_CLEAR;
              report_d = 1'b1;
            end
            default:    cmd_o.report = 1'b1;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          cmd_o.home   = 1'b1;
          cmd_o.report = report_q;
          report_d     = 1'b0;
          state_d      = S_IDLE;
        end
      end
      S_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = S_RDANT;
      end
      S_RDANT: begin
        cmd_o.rd_ant = 1'b1;
        state_d      = S_TURN;
      end
      S_TURN: begin
        cmd_o.turn   = 1'b1;
        cmd_o.report = 1'b1;
        state_d      = S_IDLE;
      end
      S_RDCELL: begin
        cmd_o.rd_cell = 1'b1;
        state_d       = S_TOG;
      end
      S_TOG: begin
        cmd_o.tog    = 1'b1;
        cmd_o.report = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Reset starts a silent clear sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      report_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      report_q <= report_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  a_step_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOVE) |=> (state_q == S_RDANT) ##1 (state_q == S_TURN))
    else $error("step sequence broken");

  a_clear_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && !sts_i.clear_last) |=> (state_q == S_CLEAR))
    else $error("clear sweep left early");

  a_report_only_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    report_q |-> (state_q == S_CLEAR))
    else $error("restart report pending outside clear sweep");

endmodule

FILE: rtl/core/langton_ant_grid_stepper.sv
// Ant grid stepper top level. A step walks the move, read-ant and turn states, a toggle the
// read-cell and toggle states, a restart a full clear sweep; an unused op reports from idle.
// One request at a time, set by the one grid port: a new start is taken only in idle.
// Reset runs a clear sweep of every grid address with busy high and no result strobe.
// The receiver cannot stall: res_o holds each result from its valid_o cycle to the next one.
// Uses lant_pkg, lant_ctrl and lant_datapath.
module langton_ant_grid_stepper import lant_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 start,
  output logic                 busy,
  input  lant_req_t            req_i,
  // result strobe
  output logic                 valid_o,
  output lant_res_t            res_o,
  // register write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i
);

  lant_cmd_t cmd;
  lant_sts_t sts;

  // Register writes are taken at any time; they are only meaningful while idle,
  // and new sizes take full effect after a restart.
  assign cfg_ready_o = 1'b1;

  // Controller: decodes the request op and walks the state sequence for it.
  lant_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (req_i.op),
    .busy_o  (busy),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  // Datapath: grid memory, ant state, size registers and result register.
  lant_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .valid_o     (valid_o),
    .res_o       (res_o)
  );

endmodule

FILE: verif/tb.sv
// Self-checking testbench for langton_ant_grid_stepper: a queue-fed request driver,
// a result monitor and a bit-accurate ant/grid predictor. Depends on lant_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
  import lant_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int GRID_STRIDE  = DEF_MAX_WIDTH;
  localparam int GRID_CELLS   = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  // A restart or the reset sweep keeps the block quiet for a whole grid clear.
  localparam int QUIET_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 8;

  // Codes the package leaves unnamed.
  localparam logic [OP_W-1:0]      OP_SPARE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start       = 1'b0;
  logic                 busy;
  lant_req_t            req         = '0;
  logic                 valid_o;
  lant_res_t            res_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DIM_W-1:0]     cfg_data_i  = '0;

  // Predictor state: grid, ant and the register copies.
  logic [GRID_CELLS-1:0] grid_bits;
  int                    ant_col;
  int                    ant_row;
  head_e                 ant_dir;
  logic [DIM_W-1:0]      cfg_width;
  logic [DIM_W-1:0]      cfg_height;

  lant_req_t request_q[$];
  lant_res_t ant_state_q[$];
  int        queued_cnt    = 0;
  int        issued_cnt    = 0;
  int        error_cnt     = 0;
  int        idle_pct      = 0;
  int        restart_spare = 3;
  int        quiet_cycles;

  langton_ant_grid_stepper i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .valid_o     (valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Register value in use: zero reads as one, anything past the built size as that size.
  function automatic int eff_dim(input logic [DIM_W-1:0] v, input int maxv);
    int lim;
    lim = (maxv < 256) ? maxv : 256;
    if (v == '0) return 1;
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  function automatic int grid_w();
    return eff_dim(cfg_width, DEF_MAX_WIDTH);
  endfunction

  function automatic int grid_h();
    return eff_dim(cfg_height, DEF_MAX_HEIGHT);
  endfunction

  // Clear the grid and home the ant, heading north.
  task automatic home_ant();
    grid_bits = '0;
    ant_col   = grid_w() / 2;
    ant_row   = grid_h() / 2;
    ant_dir   = HEAD_NORTH;
  endtask

  // Advance the predictor by one request and return the ant state it leaves behind.
  task automatic apply_request(input lant_req_t rq, output lant_res_t rs);
    int w;
    int h;
    w = grid_w();
    h = grid_h();
    case (rq.op)
      OP_STEP: begin
        grid_bits[ant_row * GRID_STRIDE + ant_col] ^= 1'b1;
        // East and south wrap on >= so an ant stranded outside a shrunk region comes home.
        case (ant_dir)
          HEAD_NORTH: ant_row = (ant_row == 0) ? h - 1 : ant_row - 1;
          HEAD_EAST:  ant_col = (ant_col >= w - 1) ? 0 : ant_col + 1;
          HEAD_SOUTH: ant_row = (ant_row >= h - 1) ? 0 : ant_row + 1;
          default:    ant_col = (ant_col == 0) ? w - 1 : ant_col - 1;
        endcase
        // Turn clockwise on white, counter-clockwise on black.
        if (grid_bits[ant_row * GRID_STRIDE + ant_col] == 1'b0)
          ant_dir = head_e'(ant_dir + 2'd1);
        else
          ant_dir = head_e'(ant_dir + 2'd3);
      end
      OP_TOGGLE: begin
        // Drop toggles that fall outside the region in use.
        if (int'(rq.cell_x) < w && int'(rq.cell_y) < h)
          grid_bits[int'(rq.cell_y) * GRID_STRIDE + int'(rq.cell_x)] ^= 1'b1;
      end
      OP_RESTART: home_ant();
      default: ;  // spare op code only reports the state
    endcase
    rs.ant_x      = COORD_W'(ant_col);
    rs.ant_y      = COORD_W'(ant_row);
    rs.heading    = ant_dir;
    rs.cell_black = grid_bits[ant_row * GRID_STRIDE + ant_col];
  endtask

  // Request driver: hold start with the request until it is taken, then load the
  // next one from the pending queue or drop start and idle. The prediction is made
  // at the edge that accepts the request.
  always @(posedge clk_i or negedge rst_ni) begin
    lant_res_t want;
    if (!rst_ni) begin
      start <= 1'b0;
      req   <= '0;
    end else begin
      if (start && !busy) begin
        apply_request(req, want);
        ant_state_q.push_back(want);
        issued_cnt++;
      end
      if (!start || !busy) begin
        if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          req   <= request_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: each strobe consumes the oldest expected ant state.
  always @(posedge clk_i) begin
    lant_res_t want;
    if (rst_ni && valid_o) begin
      if (ant_state_q.size() == 0) begin
        $error("result with no request outstanding: x %0d y %0d heading %0d black %0d",
               res_o.ant_x, res_o.ant_y, res_o.heading, res_o.cell_black);
        error_cnt++;
      end else begin
        want = ant_state_q.pop_front();
        if (res_o.ant_x !== want.ant_x) begin
          $error("ant_x: expected %0d, got %0d", want.ant_x, res_o.ant_x);
          error_cnt++;
        end
        if (res_o.ant_y !== want.ant_y) begin
          $error("ant_y: expected %0d, got %0d", want.ant_y, res_o.ant_y);
          error_cnt++;
        end
        if (res_o.heading !== want.heading) begin
          $error("heading: expected %0d, got %0d", want.heading, res_o.heading);
          error_cnt++;
        end
        if (res_o.cell_black !== want.cell_black) begin
          $error("cell_black: expected %0d, got %0d", want.cell_black, res_o.cell_black);
          error_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles without any handshake.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((start && !busy) || valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Write one register and mirror it into the predictor once the write is taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_WIDTH:  cfg_width  = val;
      CFG_HEIGHT: cfg_height = val;
      default: ;  // spare indexes change nothing
    endcase
  endtask

  task automatic push_request(input logic [OP_W-1:0] op, input int x, input int y);
    lant_req_t rq;
    rq.op     = op;
    rq.cell_x = COORD_W'(x);
    rq.cell_y = COORD_W'(y);
    request_q.push_back(rq);
    queued_cnt++;
  endtask

  // Mostly steps; toggles aim inside the region three times in four so they matter.
  task automatic push_random_request();
    int pick;
    int x;
    int y;
    pick = $urandom_range(999);
    x    = $urandom_range(255);
    y    = $urandom_range(255);
    if (pick < 700) begin
      push_request(OP_STEP, x, y);
    end else if (pick < 850) begin
      if ($urandom_range(3) != 0) begin
        x = $urandom_range(grid_w() - 1);
        y = $urandom_range(grid_h() - 1);
      end
      push_request(OP_TOGGLE, x, y);
    end else if (pick < 995 || restart_spare == 0) begin
      push_request(OP_SPARE, x, y);
    end else begin
      restart_spare--;
      push_request(OP_RESTART, x, y);
    end
  endtask

  // Wait until every request is taken and answered, then let the block settle.
  task automatic wait_drained();
    do @(posedge clk_i); while (issued_cnt != queued_cnt || ant_state_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input int w, input int h, input bit restart_first,
                           input int n_items, input int idle);
    write_reg(CFG_WIDTH, DIM_W'(w));
    write_reg(CFG_HEIGHT, DIM_W'(h));
    idle_pct = idle;
    if (restart_first) push_request(OP_RESTART, 0, 0);
    repeat (n_items) push_random_request();
    wait_drained();
  endtask

  initial begin
    cfg_width  = CFG_DIM_RESET;
    cfg_height = CFG_DIM_RESET;
    home_ant();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset state, a black cell under the ant, corner toggles,
    // a restart, then a square walk on a clean grid.
    idle_pct = 36;
    push_request(OP_SPARE, 255, 255);
    push_request(OP_TOGGLE, 128, 128);
    push_request(OP_STEP, 0, 0);
    push_request(OP_TOGGLE, 129, 127);
    push_request(OP_STEP, 255, 255);
    push_request(OP_STEP, 0, 0);
    push_request(OP_STEP, 0, 0);
    push_request(OP_TOGGLE, 0, 0);
    push_request(OP_TOGGLE, 255, 255);
    push_request(OP_TOGGLE, 255, 0);
    push_request(OP_TOGGLE, 0, 255);
    push_request(OP_TOGGLE, 0, 0);
    push_request(OP_RESTART, 170, 85);
    push_request(OP_SPARE, 0, 0);
    repeat (5) push_request(OP_STEP, 0, 0);
    wait_drained();

    // Random phases: tiny grids, out-of-range register values, and size changes
    // without a restart that strand the ant outside the region.
    run_phase(1, 1, 1'b1, 50, 36);
    run_phase(0, 511, 1'b0, 50, 36);
    run_phase(300, 1, 1'b0, 100, 36);
    run_phase(7, 5, 1'b1, 150, 53);
    run_phase(2, 256, 1'b0, 100, 53);
    run_phase(13, 2, 1'b0, 100, 53);
    run_phase(16, 16, 1'b1, 150, 0);
    // Spare register indexes must leave the size alone.
    write_reg(CFG_SPARE_LO, '0);
    write_reg(CFG_SPARE_HI, '1);
    run_phase(256, 256, 1'b1, 80, 0);

    if (error_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
